FILE: src/dvpu_pkg.sv
// Shared types and constants of the damped Verlet particle update unit.
package dvpu_pkg;

    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = 32 / DIV_BITS;

    localparam logic signed [25:0] COEF_POS  = 26'sd33470546;
    localparam logic signed [25:0] COEF_PREV = -26'sd16693330;

    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    localparam logic [2:0] REG_GRAVITY_X = 3'd0;
    localparam logic [2:0] REG_GRAVITY_Y = 3'd1;
    localparam logic [2:0] REG_GRAVITY_Z = 3'd2;
    localparam logic [2:0] REG_PUSH_X    = 3'd3;
    localparam logic [2:0] REG_PUSH_Y    = 3'd4;
    localparam logic [2:0] REG_PUSH_Z    = 3'd5;
    localparam logic [2:0] REG_DRAG      = 3'd6;
    localparam logic [2:0] REG_STEP_TIME = 3'd7;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] prev_x;
        logic signed [31:0] prev_y;
        logic signed [31:0] prev_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [23:0]        particle_mass;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] next_x;
        logic signed [31:0] next_y;
        logic signed [31:0] next_z;
        logic signed [31:0] old_x;
        logic signed [31:0] old_y;
        logic signed [31:0] old_z;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic               clipped;
    } t_out_word;

    // particle data carried alongside the arithmetic
    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] prev;
        logic [2:0][31:0] vel;
        logic [23:0]      mass;
        logic             skip;
    } t_side;

    // one lane of the pipelined divider: partial remainder, dividend/quotient shifter, sign and overflow flags
    typedef struct packed {
        logic [23:0] rem;
        logic [31:0] dq;
        logic        neg;
        logic        ovf;
    } t_div;

endpackage

FILE: src/damped_verlet_particle_update_unit.sv
// Top level: pipelined damped Verlet update of one particle per word.

// Takes one particle word per cycle while o_in_stall is low and returns one result word
// per particle, in order. Most of the pipeline is the force-over-mass divider, which
// resolves two quotient bits per stage over sixteen stages; force products, saturation,
// the step products and the final sums take the other stages. A stalled output freezes
// the whole pipeline and raises o_in_stall. Configuration registers are written through
// i_cfg_we / i_cfg_index / i_cfg_data; the user must write them only while no word is in
// flight, as the block itself has no check for this.
module damped_verlet_particle_update_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  dvpu_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output dvpu_pkg::t_out_word  o_out_word
);

    function automatic dvpu_pkg::t_div div_step(input dvpu_pkg::t_div d,
                                                input logic [23:0] m);
        dvpu_pkg::t_div o;
        logic [24:0]    t;
        o = d;
        for (int k = 0; k < dvpu_pkg::DIV_BITS; k++) begin
            t    = {o.rem, o.dq[31]};
            o.dq = {o.dq[30:0], 1'b0};
            if (t >= {1'b0, m}) begin
                o.rem   = 24'(t - {1'b0, m});
                o.dq[0] = 1'b1;
            end else begin
                o.rem = t[23:0];
            end
        end
        return o;
    endfunction

    function automatic logic sat_hit(input logic signed [35:0] x);
        return (x > 36'(dvpu_pkg::S32_MAX)) || (x < 36'(dvpu_pkg::S32_MIN));
    endfunction

    function automatic logic [31:0] sat_val(input logic signed [35:0] x);
        logic [31:0] v;
        if (x > 36'(dvpu_pkg::S32_MAX)) begin
            v = dvpu_pkg::S32_MAX;
        end else if (x < 36'(dvpu_pkg::S32_MIN)) begin
            v = dvpu_pkg::S32_MIN;
        end else begin
            v = x[31:0];
        end
        return v;
    endfunction

    // configuration
    logic signed [31:0] r_grav [3];
    logic signed [31:0] r_push [3];
    logic [23:0]        r_drag;
    logic [15:0]        r_dt;
    logic [31:0]        r_dt2;

    logic en;

    // stage registers
    logic                r_a_valid;
    dvpu_pkg::t_in_word  r_a;
    logic                r_b_valid;
    dvpu_pkg::t_side     r_b_side;
    logic signed [56:0]  r_b_gm [3];
    logic signed [56:0]  r_b_dv [3];
    logic                r_dv   [dvpu_pkg::DIV_STAGES+1];
    dvpu_pkg::t_side     r_ds   [dvpu_pkg::DIV_STAGES+1];
    dvpu_pkg::t_div      r_d    [dvpu_pkg::DIV_STAGES+1][3];
    logic                r_e_valid;
    dvpu_pkg::t_side     r_e_side;
    logic signed [31:0]  r_e_acc [3];
    logic                r_e_clip;
    logic                r_f_valid;
    dvpu_pkg::t_side     r_f_side;
    logic signed [48:0]  r_f_adt  [3];
    logic signed [64:0]  r_f_adt2 [3];
    logic signed [57:0]  r_f_pp   [3];
    logic signed [57:0]  r_f_qq   [3];
    logic                r_f_clip;
    logic                r_g_valid;
    dvpu_pkg::t_side     r_g_side;
    logic signed [34:0]  r_g_nv [3];
    logic signed [35:0]  r_g_nx [3];
    logic                r_g_clip;
    logic                r_out_valid;
    dvpu_pkg::t_out_word r_out;

    dvpu_pkg::t_side     a_side;
    dvpu_pkg::t_side     n_c_side;
    dvpu_pkg::t_div      n_c_div [3];
    logic signed [31:0]  n_e_acc [3];
    logic [2:0]          n_e_clip;
    logic signed [34:0]  n_g_nv [3];
    logic signed [35:0]  n_g_nx [3];
    dvpu_pkg::t_out_word n_out;

    // advance everything unless the output word is held
    assign en          = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav[0] <= '0;
            r_grav[1] <= -32'sd65536;
            r_grav[2] <= '0;
            r_push[0] <= '0;
            r_push[1] <= '0;
            r_push[2] <= '0;
            r_drag    <= 24'd32768;
            r_dt      <= 16'd1092;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dvpu_pkg::REG_GRAVITY_X: r_grav[0] <= i_cfg_data;
                dvpu_pkg::REG_GRAVITY_Y: r_grav[1] <= i_cfg_data;
                dvpu_pkg::REG_GRAVITY_Z: r_grav[2] <= i_cfg_data;
                dvpu_pkg::REG_PUSH_X:    r_push[0] <= i_cfg_data;
                dvpu_pkg::REG_PUSH_Y:    r_push[1] <= i_cfg_data;
                dvpu_pkg::REG_PUSH_Z:    r_push[2] <= i_cfg_data;
                dvpu_pkg::REG_DRAG:      r_drag    <= i_cfg_data[23:0];
                dvpu_pkg::REG_STEP_TIME: r_dt      <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_dt2 <= 32'(r_dt) * 32'(r_dt);
    end

    // stage A: input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_in_valid;
        end
        if (en) begin
            r_a <= i_in_word;
        end
    end

    always_comb begin
        a_side.pos  = {r_a.pos_z,  r_a.pos_y,  r_a.pos_x};
        a_side.prev = {r_a.prev_z, r_a.prev_y, r_a.prev_x};
        a_side.vel  = {r_a.vel_z,  r_a.vel_y,  r_a.vel_x};
        a_side.mass = (r_a.particle_mass == '0) ? 24'd1 : r_a.particle_mass;
        a_side.skip = (r_a.prev_x == '0) && (r_a.prev_y == '0) && (r_a.prev_z == '0);
    end

    // stage B: gravity and drag products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
        if (en) begin
            r_b_side <= a_side;
            for (int i = 0; i < 3; i++) begin
                r_b_gm[i] <= r_grav[i] * $signed({1'b0, a_side.mass});
                r_b_dv[i] <= $signed({1'b0, r_drag}) * $signed(a_side.vel[i]);
            end
        end
    end

    // stage C: net force, magnitude, quotient range check
    always_comb begin
        logic signed [58:0] force_v;
        logic [58:0]        mag;
        n_c_side = r_b_side;
        for (int i = 0; i < 3; i++) begin
            force_v = $signed({r_push[i], 16'b0}) + 59'(r_b_gm[i]) - 59'(r_b_dv[i]);
            mag     = force_v[58] ? 59'(-force_v) : 59'(force_v);
            n_c_div[i].neg = force_v[58];
            // quotient needs more than 32 bits when the high part reaches the mass
            n_c_div[i].ovf = mag[58:32] >= 27'(r_b_side.mass);
            n_c_div[i].rem = mag[55:32];
            n_c_div[i].dq  = mag[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_b_valid;
        end
        if (en) begin
            r_ds[0] <= n_c_side;
            for (int i = 0; i < 3; i++) begin
                r_d[0][i] <= n_c_div[i];
            end
        end
    end

    // divider stages
    for (genvar s = 1; s <= dvpu_pkg::DIV_STAGES; s++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[s] <= 1'b0;
            end else if (en) begin
                r_dv[s] <= r_dv[s-1];
            end
            if (en) begin
                r_ds[s] <= r_ds[s-1];
                for (int i = 0; i < 3; i++) begin
                    r_d[s][i] <= div_step(r_d[s-1][i], r_ds[s-1].mass);
                end
            end
        end
    end

    // stage E: sign and saturate the acceleration
    always_comb begin
        dvpu_pkg::t_div d;
        for (int i = 0; i < 3; i++) begin
            d = r_d[dvpu_pkg::DIV_STAGES][i];
            n_e_clip[i] = 1'b0;
            if (d.ovf) begin
                n_e_acc[i]  = d.neg ? dvpu_pkg::S32_MIN : dvpu_pkg::S32_MAX;
                n_e_clip[i] = 1'b1;
            end else if (d.neg) begin
                if (d.dq > 32'(dvpu_pkg::S32_MIN)) begin
                    n_e_acc[i]  = dvpu_pkg::S32_MIN;
                    n_e_clip[i] = 1'b1;
                end else begin
                    n_e_acc[i] = -$signed(d.dq);
                end
            end else if (d.dq[31]) begin
                n_e_acc[i]  = dvpu_pkg::S32_MAX;
                n_e_clip[i] = 1'b1;
            end else begin
                n_e_acc[i] = $signed(d.dq);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (en) begin
            r_e_valid <= r_dv[dvpu_pkg::DIV_STAGES];
        end
        if (en) begin
            r_e_side <= r_ds[dvpu_pkg::DIV_STAGES];
            r_e_acc  <= n_e_acc;
            r_e_clip <= |n_e_clip;
        end
    end

    // stage F: step products and damping coefficients
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (en) begin
            r_f_valid <= r_e_valid;
        end
        if (en) begin
            r_f_side <= r_e_side;
            r_f_clip <= r_e_clip;
            for (int i = 0; i < 3; i++) begin
                r_f_adt[i]  <= r_e_acc[i] * $signed({1'b0, r_dt});
                r_f_adt2[i] <= r_e_acc[i] * $signed({1'b0, r_dt2});
                r_f_pp[i]   <= $signed(r_e_side.pos[i]) * dvpu_pkg::COEF_POS;
                r_f_qq[i]   <= $signed(r_e_side.prev[i]) * dvpu_pkg::COEF_PREV;
            end
        end
    end

    // stage G: round half up and sum
    always_comb begin
        logic signed [49:0] dvr;
        logic signed [59:0] sum;
        for (int i = 0; i < 3; i++) begin
            dvr       = 50'(r_f_adt[i]) + 50'sd32768;
            n_g_nv[i] = 35'($signed(r_f_side.vel[i])) + 35'($signed(dvr[49:16]));
            sum       = 60'(r_f_pp[i]) + 60'(r_f_qq[i]) + 60'($signed(r_f_adt2[i][64:8]))
                        + 60'sd8388608;
            n_g_nx[i] = sum[59:24];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else if (en) begin
            r_g_valid <= r_f_valid;
        end
        if (en) begin
            r_g_side <= r_f_side;
            r_g_clip <= r_f_clip;
            r_g_nv   <= n_g_nv;
            r_g_nx   <= n_g_nx;
        end
    end

    // output stage: saturate, or pass the particle through on a zero previous position
    always_comb begin
        logic [2:0] hit;
        logic [2:0][31:0] nx;
        logic [2:0][31:0] nv;
        for (int i = 0; i < 3; i++) begin
            hit[i] = sat_hit(r_g_nx[i]) || sat_hit(36'(r_g_nv[i]));
            nx[i]  = sat_val(r_g_nx[i]);
            nv[i]  = sat_val(36'(r_g_nv[i]));
        end
        if (r_g_side.skip) begin
            nx  = r_g_side.pos;
            nv  = r_g_side.vel;
            hit = '0;
        end
        n_out.next_x    = nx[0];
        n_out.next_y    = nx[1];
        n_out.next_z    = nx[2];
        n_out.old_x     = r_g_side.pos[0];
        n_out.old_y     = r_g_side.pos[1];
        n_out.old_z     = r_g_side.pos[2];
        n_out.new_vel_x = nv[0];
        n_out.new_vel_y = nv[1];
        n_out.new_vel_z = nv[2];
        n_out.clipped   = (|hit) || (r_g_clip && !r_g_side.skip);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_g_valid;
        end
        if (en) begin
            r_out <= n_out;
        end
    end

    a_stall_freezes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> o_in_stall)
        else $error("pipeline not frozen while output word held");

    a_div_ovf_clips : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_dv[dvpu_pkg::DIV_STAGES]
            && (r_d[dvpu_pkg::DIV_STAGES][0].ovf || r_d[dvpu_pkg::DIV_STAGES][1].ovf
                || r_d[dvpu_pkg::DIV_STAGES][2].ovf)) |=> r_e_clip)
        else $error("acceleration overflow did not set clip");

    a_skip_no_clip : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_g_valid && r_g_side.skip) |=> (o_out_valid && !o_out_word.clipped))
        else $error("pass-through word flagged as clipped");

endmodule
